// File: rtl/core/bbla_pkg.sv
package bbla_pkg;

    localparam int CfgAddrBits = 4;
    localparam int CfgDataBits = 32;

    typedef enum logic [1:0] {
        REG_CB_LIMIT  = 2'd0,
        REG_AUX_LIMIT = 2'd1,
        REG_DEBOUNCE  = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        VS_OTHER  = 2'd0,
        VS_READY  = 2'd1,
        VS_PARKED = 2'd2,
        VS_OTHER2 = 2'd3
    } t_vstate;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_RAISED    = 2'd1,
        EV_DISMISSED = 2'd2
    } t_event;

    typedef struct packed {
        logic        tick;
        t_vstate     vehicle_state;
        logic        main_pack_a_present;
        logic        main_pack_b_present;
        logic        cb_present;
        logic        cb_charge_valid;
        logic [6:0]  cb_charge;
        logic        aux_voltage_valid;
        logic [15:0] aux_voltage;
    } t_item;

    typedef struct packed {
        logic   cb_warning_on;
        logic   aux_warning_on;
        t_event cb_event;
        t_event aux_event;
    } t_result;

    typedef struct packed {
        t_vstate last_vehicle_state;
        logic    last_no_main;
        logic    armed_by_park;
        logic    armed_by_removal;
        logic    cb_shown;
        logic    aux_shown;
    } t_flags;

    typedef struct packed {
        logic [6:0]  cb_charge_limit;
        logic [15:0] aux_voltage_limit;
        logic [15:0] debounce_ticks;
    } t_cfg;

    localparam t_flags FlagsReset = '{
        last_vehicle_state: VS_OTHER,
        last_no_main:       1'b1,
        armed_by_park:      1'b0,
        armed_by_removal:   1'b0,
        cb_shown:           1'b0,
        aux_shown:          1'b0
    };

    localparam t_cfg CfgReset = '{
        cb_charge_limit:   7'd10,
        aux_voltage_limit: 16'd11000,
        debounce_ticks:    16'd2000
    };

endpackage

// File: rtl/core/bbla_step.sv
module bbla_step #(
    parameter int TIMER_BITS = 16
) (
    input  bbla_pkg::t_item         i_item,
    input  bbla_pkg::t_cfg          i_cfg,
    input  bbla_pkg::t_flags        i_flags,
    input  logic [TIMER_BITS-1:0]   i_timer,
    output bbla_pkg::t_flags        o_flags,
    output logic [TIMER_BITS-1:0]   o_timer,
    output bbla_pkg::t_result       o_result
);
    import bbla_pkg::*;

    localparam int LoadBits = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    logic                  no_main;
    logic                  cb_low;
    logic                  aux_low;
    logic                  relevant;
    logic [LoadBits-1:0]   ticks_ext;
    logic [LoadBits-1:0]   max_ext;
    logic [TIMER_BITS-1:0] load_value;
    logic [TIMER_BITS-1:0] timer_dec;
    t_flags                flags;
    t_event                cb_ev;
    t_event                aux_ev;

    assign no_main = !i_item.main_pack_a_present && !i_item.main_pack_b_present;
    assign cb_low  = i_item.cb_present && i_item.cb_charge_valid
                     && (i_item.cb_charge < i_cfg.cb_charge_limit);
    assign aux_low = i_item.aux_voltage_valid
                     && (i_item.aux_voltage < i_cfg.aux_voltage_limit);
    assign timer_dec = i_timer - TIMER_BITS'(1);

    // debounce load value, zero counts as one, saturate to timer range
    always_comb begin
        ticks_ext = LoadBits'(i_cfg.debounce_ticks);
        max_ext   = LoadBits'({TIMER_BITS{1'b1}});
        if (ticks_ext > max_ext) begin
            load_value = '1;
        end else begin
            load_value = ticks_ext[TIMER_BITS-1:0];
        end
        if (load_value == '0) begin
            load_value = TIMER_BITS'(1);
        end
    end

    always_comb begin
        flags    = i_flags;
        o_timer  = i_timer;
        cb_ev    = EV_NONE;
        aux_ev   = EV_NONE;
        relevant = 1'b0;

        if (i_flags.last_vehicle_state == VS_READY && i_item.vehicle_state == VS_PARKED) begin
            flags.armed_by_park = 1'b1;
        end
        if (!i_flags.last_no_main && no_main) begin
            flags.armed_by_removal = 1'b1;
        end
        flags.last_vehicle_state = i_item.vehicle_state;
        flags.last_no_main       = no_main;

        if (!cb_low && i_flags.cb_shown) begin
            flags.cb_shown = 1'b0;
            cb_ev          = EV_DISMISSED;
        end
        if (!aux_low && i_flags.aux_shown) begin
            flags.aux_shown = 1'b0;
            aux_ev          = EV_DISMISSED;
        end

        // countdown and expiry
        if (i_item.tick && i_timer != '0) begin
            o_timer = timer_dec;
            if (timer_dec == '0) begin
                relevant = (flags.armed_by_park && i_item.vehicle_state == VS_PARKED)
                           || (flags.armed_by_removal && no_main);
                flags.armed_by_park    = 1'b0;
                flags.armed_by_removal = 1'b0;
                if (relevant) begin
                    if (cb_low && !flags.cb_shown) begin
                        flags.cb_shown = 1'b1;
                        cb_ev          = EV_RAISED;
                    end
                    if (aux_low && !flags.aux_shown) begin
                        flags.aux_shown = 1'b1;
                        aux_ev          = EV_RAISED;
                    end
                end
            end
        end

        if ((flags.armed_by_park || flags.armed_by_removal) && o_timer == '0) begin
            o_timer = load_value;
        end

        o_flags = flags;
        o_result.cb_warning_on  = flags.cb_shown;
        o_result.aux_warning_on = flags.aux_shown;
        o_result.cb_event       = cb_ev;
        o_result.aux_event      = aux_ev;
    end

endmodule

// File: rtl/core/backup_battery_low_alert.sv
// Backup battery low alert. Takes one status snapshot per transfer and returns one
// result per transfer, one transfer per cycle while the receiver does not stall; each
// result passes an input register, then the evaluate logic into the result
// register. Parking after ready-to-drive, or pulling the last main pack, arms a
// debounce of debounce_ticks ticks (0 acts as 1, capped at the TIMER_BITS range);
// on expiry the arming is checked against the current snapshot and low connectivity
// backup or auxiliary packs raise their warning. A shown warning is dismissed in the
// first snapshot where its pack is not low. Registers on the APB port: cb_charge_limit
// at 0x0, aux_voltage_limit at 0x4, debounce_ticks at 0x8; write them only while idle.
module backup_battery_low_alert #(
    parameter int TIMER_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bbla_pkg::CfgAddrBits-1:0] paddr,
    input  logic [bbla_pkg::CfgDataBits-1:0] pwdata,
    output logic [bbla_pkg::CfgDataBits-1:0] prdata,
    output logic                            pready,

    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_tick,
    input  logic [1:0]                      i_vehicle_state,
    input  logic                            i_main_pack_a_present,
    input  logic                            i_main_pack_b_present,
    input  logic                            i_cb_present,
    input  logic                            i_cb_charge_valid,
    input  logic [6:0]                      i_cb_charge,
    input  logic                            i_aux_voltage_valid,
    input  logic [15:0]                     i_aux_voltage,

    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_cb_warning_on,
    output logic                            o_aux_warning_on,
    output logic [1:0]                      o_cb_event,
    output logic [1:0]                      o_aux_event
);
    import bbla_pkg::*;

    t_cfg                  r_cfg;
    t_item                 r_item;
    logic                  r_in_vld;
    logic                  r_out_vld;
    t_result               r_result;
    t_flags                r_flags;
    logic [TIMER_BITS-1:0] r_timer;

    t_flags                n_flags;
    logic [TIMER_BITS-1:0] n_timer;
    t_result               n_result;

    logic                  cfg_write;
    t_reg_idx              reg_idx;
    logic                  out_free;
    logic                  step_go;
    logic                  in_take;

    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (reg_idx)
            REG_CB_LIMIT:  prdata = CfgDataBits'(r_cfg.cb_charge_limit);
            REG_AUX_LIMIT: prdata = CfgDataBits'(r_cfg.aux_voltage_limit);
            REG_DEBOUNCE:  prdata = CfgDataBits'(r_cfg.debounce_ticks);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CfgReset;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_CB_LIMIT:  r_cfg.cb_charge_limit   <= pwdata[6:0];
                REG_AUX_LIMIT: r_cfg.aux_voltage_limit <= pwdata[15:0];
                REG_DEBOUNCE:  r_cfg.debounce_ticks    <= pwdata[15:0];
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    // two-stage flow: input register, then result register
    assign out_free = !r_out_vld || !i_stall;
    assign step_go  = r_in_vld && out_free;
    assign o_stall  = r_in_vld && !out_free;
    assign in_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (step_go) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.tick                <= i_tick;
            r_item.vehicle_state       <= t_vstate'(i_vehicle_state);
            r_item.main_pack_a_present <= i_main_pack_a_present;
            r_item.main_pack_b_present <= i_main_pack_b_present;
            r_item.cb_present          <= i_cb_present;
            r_item.cb_charge_valid     <= i_cb_charge_valid;
            r_item.cb_charge           <= i_cb_charge;
            r_item.aux_voltage_valid   <= i_aux_voltage_valid;
            r_item.aux_voltage         <= i_aux_voltage;
        end
    end

    bbla_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .i_item   (r_item),
        .i_cfg    (r_cfg),
        .i_flags  (r_flags),
        .i_timer  (r_timer),
        .o_flags  (n_flags),
        .o_timer  (n_timer),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags   <= FlagsReset;
            r_timer   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (step_go) begin
                r_flags   <= n_flags;
                r_timer   <= n_timer;
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_result <= n_result;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_cb_warning_on  = r_result.cb_warning_on;
    assign o_aux_warning_on = r_result.aux_warning_on;
    assign o_cb_event       = r_result.cb_event;
    assign o_aux_event      = r_result.aux_event;

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bbla_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        t_item   snap;
        bit      pinned;
        t_result want;
    } t_script_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [CfgAddrBits-1:0] paddr = '0;
    logic [CfgDataBits-1:0] pwdata = '0;
    logic [CfgDataBits-1:0] prdata;
    logic                   pready;

    logic        i_valid = 1'b0;
    logic        o_stall;
    t_item       offer = '0;
    bit          offer_pinned = 1'b0;
    t_result     offer_want = '0;
    logic        i_tick;
    logic [1:0]  i_vehicle_state;
    logic        i_main_pack_a_present;
    logic        i_main_pack_b_present;
    logic        i_cb_present;
    logic        i_cb_charge_valid;
    logic [6:0]  i_cb_charge;
    logic        i_aux_voltage_valid;
    logic [15:0] i_aux_voltage;

    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_cb_warning_on;
    logic        o_aux_warning_on;
    logic [1:0]  o_cb_event;
    logic [1:0]  o_aux_event;

    t_flags      alert_flags = FlagsReset;
    t_cfg        alert_cfg = CfgReset;
    logic [15:0] debounce_left = '0;
    t_result     pending_results[$];
    t_script_row script[$];

    t_vstate walk_vs = VS_OTHER;
    logic    walk_a = 1'b1;
    logic    walk_b = 1'b1;

    bit calm = 1'b0;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int fail_count = 0;
    int cycle_count = 0;

    assign i_tick                = offer.tick;
    assign i_vehicle_state       = offer.vehicle_state;
    assign i_main_pack_a_present = offer.main_pack_a_present;
    assign i_main_pack_b_present = offer.main_pack_b_present;
    assign i_cb_present          = offer.cb_present;
    assign i_cb_charge_valid     = offer.cb_charge_valid;
    assign i_cb_charge           = offer.cb_charge;
    assign i_aux_voltage_valid   = offer.aux_voltage_valid;
    assign i_aux_voltage         = offer.aux_voltage;

    backup_battery_low_alert uut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_tick                (i_tick),
        .i_vehicle_state       (i_vehicle_state),
        .i_main_pack_a_present (i_main_pack_a_present),
        .i_main_pack_b_present (i_main_pack_b_present),
        .i_cb_present          (i_cb_present),
        .i_cb_charge_valid     (i_cb_charge_valid),
        .i_cb_charge           (i_cb_charge),
        .i_aux_voltage_valid   (i_aux_voltage_valid),
        .i_aux_voltage         (i_aux_voltage),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_cb_warning_on       (o_cb_warning_on),
        .o_aux_warning_on      (o_aux_warning_on),
        .o_cb_event            (o_cb_event),
        .o_aux_event           (o_aux_event)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_result predict_alert(input t_item s);
        t_result r;
        logic    no_main;
        logic    cb_low;
        logic    aux_low;
        logic    relevant;
        r = '0;
        no_main = !s.main_pack_a_present && !s.main_pack_b_present;
        cb_low = s.cb_present && s.cb_charge_valid &&
                 (s.cb_charge < alert_cfg.cb_charge_limit);
        aux_low = s.aux_voltage_valid && (s.aux_voltage < alert_cfg.aux_voltage_limit);

        if (alert_flags.last_vehicle_state == VS_READY && s.vehicle_state == VS_PARKED) begin
            alert_flags.armed_by_park = 1'b1;
        end
        if (!alert_flags.last_no_main && no_main) begin
            alert_flags.armed_by_removal = 1'b1;
        end
        alert_flags.last_vehicle_state = s.vehicle_state;
        alert_flags.last_no_main = no_main;

        if (!cb_low && alert_flags.cb_shown) begin
            alert_flags.cb_shown = 1'b0;
            r.cb_event = EV_DISMISSED;
        end
        if (!aux_low && alert_flags.aux_shown) begin
            alert_flags.aux_shown = 1'b0;
            r.aux_event = EV_DISMISSED;
        end

        if (s.tick && debounce_left != 0) begin
            debounce_left = debounce_left - 16'd1;
            if (debounce_left == 0) begin
                relevant = (alert_flags.armed_by_park && s.vehicle_state == VS_PARKED) ||
                           (alert_flags.armed_by_removal && no_main);
                alert_flags.armed_by_park = 1'b0;
                alert_flags.armed_by_removal = 1'b0;
                if (relevant && cb_low && !alert_flags.cb_shown) begin
                    alert_flags.cb_shown = 1'b1;
                    r.cb_event = EV_RAISED;
                end
                if (relevant && aux_low && !alert_flags.aux_shown) begin
                    alert_flags.aux_shown = 1'b1;
                    r.aux_event = EV_RAISED;
                end
            end
        end

        // zero debounce counts as one tick
        if ((alert_flags.armed_by_park || alert_flags.armed_by_removal) && debounce_left == 0) begin
            debounce_left = (alert_cfg.debounce_ticks == 0) ? 16'd1 : alert_cfg.debounce_ticks;
        end

        r.cb_warning_on = alert_flags.cb_shown;
        r.aux_warning_on = alert_flags.aux_shown;
        return r;
    endfunction

    function automatic t_item mk(input int tick, input t_vstate vs, input int a,
                                 input int b, input int cbp, input int cbv,
                                 input logic [6:0] cbc, input int auxv,
                                 input logic [15:0] aux);
        t_item s;
        s.tick = 1'(tick);
        s.vehicle_state = vs;
        s.main_pack_a_present = 1'(a);
        s.main_pack_b_present = 1'(b);
        s.cb_present = 1'(cbp);
        s.cb_charge_valid = 1'(cbv);
        s.cb_charge = cbc;
        s.aux_voltage_valid = 1'(auxv);
        s.aux_voltage = aux;
        return s;
    endfunction

    function automatic t_result outcome(input int cb_on, input int aux_on,
                                        input t_event cb_ev, input t_event aux_ev);
        t_result r;
        r.cb_warning_on = 1'(cb_on);
        r.aux_warning_on = 1'(aux_on);
        r.cb_event = cb_ev;
        r.aux_event = aux_ev;
        return r;
    endfunction

    function automatic t_item random_snapshot();
        t_item       s;
        logic [31:0] raw;
        int          near;
        // occasional pure noise
        if ($urandom_range(99) < 12) begin
            raw = $urandom;
            s = raw[$bits(t_item)-1:0];
            return s;
        end
        if ($urandom_range(99) < 25) begin
            if ($urandom_range(9) < 8) begin
                walk_vs = (walk_vs == VS_READY) ? VS_PARKED : VS_READY;
            end else begin
                walk_vs = t_vstate'($urandom_range(3));
            end
        end
        if ($urandom_range(99) < 8) begin
            walk_a = ~walk_a;
        end
        if ($urandom_range(99) < 8) begin
            walk_b = ~walk_b;
        end
        s.tick = 1'($urandom_range(1));
        s.vehicle_state = walk_vs;
        s.main_pack_a_present = walk_a;
        s.main_pack_b_present = walk_b;
        s.cb_present = ($urandom_range(9) != 0);
        s.cb_charge_valid = ($urandom_range(9) != 0);
        if ($urandom_range(1) == 1) begin
            near = int'(alert_cfg.cb_charge_limit) - 3 + int'($urandom_range(5));
            if (near < 0) near = 0;
            if (near > 127) near = 127;
            s.cb_charge = near[6:0];
        end else begin
            s.cb_charge = 7'($urandom_range(127));
        end
        s.aux_voltage_valid = ($urandom_range(9) != 0);
        if ($urandom_range(1) == 1) begin
            near = int'(alert_cfg.aux_voltage_limit) - 16 + int'($urandom_range(31));
            if (near < 0) near = 0;
            if (near > 65535) near = 65535;
            s.aux_voltage = near[15:0];
        end else begin
            s.aux_voltage = 16'($urandom_range(65535));
        end
        return s;
    endfunction

    task automatic add_step(input t_item s, input bit pin = 1'b0, input t_result w = '0);
        t_script_row row;
        row.snap = s;
        row.pinned = pin;
        row.want = w;
        script.push_back(row);
    endtask

    // all tasks below start and end at a falling edge
    task automatic reg_check(input t_reg_idx idx, input logic [31:0] want);
        logic [31:0] got;
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        if (got !== want) begin
            $error("register %s: expected %0d, got %0d", idx.name(), want, got);
            fail_count++;
        end
    endtask

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] value);
        logic [31:0] kept;
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_CB_LIMIT: begin
                alert_cfg.cb_charge_limit = value[6:0];
                kept = {25'd0, value[6:0]};
            end
            REG_AUX_LIMIT: begin
                alert_cfg.aux_voltage_limit = value[15:0];
                kept = {16'd0, value[15:0]};
            end
            default: begin
                alert_cfg.debounce_ticks = value[15:0];
                kept = {16'd0, value[15:0]};
            end
        endcase
        reg_check(idx, kept);
    endtask

    task automatic offer_item(input t_item s, input bit pin, input t_result w);
        while (!calm && $urandom_range(99) < 30) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        offer = s;
        offer_pinned = pin;
        offer_want = w;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_phase(input logic [6:0] cb_limit, input logic [15:0] aux_limit,
                             input logic [15:0] ticks, input int count, input bit quiet,
                             input bit squeeze);
        reg_write(REG_CB_LIMIT, {25'd0, cb_limit});
        reg_write(REG_AUX_LIMIT, {16'd0, aux_limit});
        reg_write(REG_DEBOUNCE, {16'd0, ticks});
        calm = quiet;
        if (squeeze) begin
            hold_request = 1'b1;
        end
        repeat (count) begin
            offer_item(random_snapshot(), 1'b0, '0);
        end
        i_valid = 1'b0;
        calm = 1'b0;
        wait_drained();
    endtask

    // receiver side: random stall, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            i_stall = 1'b1;
            hold_left--;
        end else begin
            i_stall = !calm && ($urandom_range(99) < 30);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result got;
        if (i_rst_n && i_valid && !o_stall) begin
            want = predict_alert(offer);
            pending_results.push_back(offer_pinned ? offer_want : want);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            got.cb_warning_on = o_cb_warning_on;
            got.aux_warning_on = o_aux_warning_on;
            got.cb_event = t_event'(o_cb_event);
            got.aux_event = t_event'(o_aux_event);
            if (pending_results.size() == 0) begin
                $error("result transfer with no expectation pending");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.cb_warning_on !== want.cb_warning_on) begin
                    $error("cb_warning_on: expected %0d, got %0d",
                           want.cb_warning_on, got.cb_warning_on);
                    fail_count++;
                end
                if (got.aux_warning_on !== want.aux_warning_on) begin
                    $error("aux_warning_on: expected %0d, got %0d",
                           want.aux_warning_on, got.aux_warning_on);
                    fail_count++;
                end
                if (got.cb_event !== want.cb_event) begin
                    $error("cb_event: expected %0d, got %0d", want.cb_event, got.cb_event);
                    fail_count++;
                end
                if (got.aux_event !== want.aux_event) begin
                    $error("aux_event: expected %0d, got %0d", want.aux_event, got.aux_event);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        reg_check(REG_CB_LIMIT, {25'd0, CfgReset.cb_charge_limit});
        reg_check(REG_AUX_LIMIT, {16'd0, CfgReset.aux_voltage_limit});
        reg_check(REG_DEBOUNCE, {16'd0, CfgReset.debounce_ticks});

        reg_write(REG_CB_LIMIT, 32'd100);
        reg_write(REG_AUX_LIMIT, 32'd65535);
        reg_write(REG_DEBOUNCE, 32'd0);

        // boot: no edge from the reset baselines
        add_step(mk(0, VS_OTHER, 0, 0, 0, 0, 7'd0, 0, 16'd0), 1'b1,
                 outcome(0, 0, EV_NONE, EV_NONE));
        add_step(mk(1, VS_READY, 1, 1, 1, 1, 7'd0, 1, 16'd0), 1'b1,
                 outcome(0, 0, EV_NONE, EV_NONE));
        // park edge, then expiry raises both
        add_step(mk(0, VS_PARKED, 1, 1, 1, 1, 7'd0, 1, 16'd0));
        add_step(mk(1, VS_PARKED, 1, 1, 1, 1, 7'd0, 1, 16'd0), 1'b1,
                 outcome(1, 1, EV_RAISED, EV_RAISED));
        add_step(mk(1, VS_PARKED, 1, 1, 1, 1, 7'd100, 1, 16'd65535), 1'b1,
                 outcome(0, 0, EV_DISMISSED, EV_DISMISSED));
        // removal of the last main pack
        add_step(mk(0, VS_OTHER2, 1, 0, 1, 1, 7'd127, 1, 16'd65535));
        add_step(mk(1, VS_OTHER2, 0, 0, 1, 1, 7'd99, 1, 16'd65534));
        add_step(mk(1, VS_OTHER, 0, 0, 1, 1, 7'd99, 1, 16'd65534));
        add_step(mk(0, VS_OTHER, 0, 0, 0, 1, 7'd99, 1, 16'd65534));
        add_step(mk(0, VS_OTHER, 0, 0, 0, 1, 7'd99, 0, 16'd65534));
        // armed but no longer parked at expiry
        add_step(mk(0, VS_READY, 1, 0, 1, 1, 7'd0, 1, 16'd0));
        add_step(mk(0, VS_PARKED, 1, 0, 1, 1, 7'd0, 1, 16'd0));
        add_step(mk(1, VS_READY, 1, 0, 1, 1, 7'd0, 1, 16'd0));
        // backup charge reading missing
        add_step(mk(1, VS_PARKED, 1, 0, 1, 0, 7'd0, 1, 16'd0));
        add_step(mk(1, VS_PARKED, 1, 0, 1, 0, 7'd0, 1, 16'd0));
        // park and removal in the same snapshot
        add_step(mk(0, VS_READY, 1, 1, 1, 1, 7'd0, 1, 16'd0));
        add_step(mk(0, VS_PARKED, 0, 0, 1, 1, 7'd0, 1, 16'd0));
        add_step(mk(1, VS_OTHER, 0, 0, 1, 1, 7'd0, 1, 16'd0));
        add_step(mk(1, VS_OTHER, 0, 0, 1, 1, 7'd0, 1, 16'd0));
        add_step(mk(1, VS_OTHER2, 1, 1, 1, 1, 7'd127, 1, 16'd65535));

        foreach (script[k]) begin
            offer_item(script[k].snap, script[k].pinned, script[k].want);
        end
        i_valid = 1'b0;
        wait_drained();

        run_phase(7'd10, 16'd11000, 16'd2, 350, 1'b0, 1'b1);
        run_phase(7'd0, 16'd0, 16'd1, 200, 1'b1, 1'b0);
        run_phase(7'd100, 16'd65535, 16'd0, 350, 1'b0, 1'b0);
        run_phase(7'($urandom_range(100)), 16'($urandom_range(65535)),
                  16'($urandom_range(6, 1)), 400, 1'b0, 1'b0);
        run_phase(7'd55, 16'd12000, 16'd4, 400, 1'b0, 1'b0);
        // longest debounce last, a timer loaded from here on never expires
        run_phase(7'd100, 16'd65535, 16'd65535, 200, 1'b0, 1'b0);

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
